// ===== hdl/lrukc_pkg.sv =====
package lrukc_pkg;

    // table geometry
    localparam int ENTRIES    = 16;
    localparam int DATA_WIDTH = 32;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int KEY_W  = 64;
    localparam int DIN_W  = 32;
    localparam int DOUT_W = 32;
    localparam int OCC_W  = 5;
    localparam int CAP_W  = 5;

    // derived widths
    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic              vld;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [DIN_W-1:0]  data_in;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [DOUT_W-1:0] data_out;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    typedef struct packed {
        logic               busy;
        logic [CNT_W-1:0]   live;
        logic [ENTRIES-1:0] valid_map;
    } t_stat;

endpackage

// ===== hdl/lrukc_if.sv =====
interface lrukc_in_if import lrukc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [DIN_W-1:0]  data_in;

    modport source (output valid, output op, output key, output data_in, input ready);
    modport sink   (input valid, input op, input key, input data_in, output ready);
endinterface

interface lrukc_out_if import lrukc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DOUT_W-1:0] data_out;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output hit, output data_out, output evicted,
                    output evicted_key, output occupancy, input ready);
    modport sink   (input valid, input hit, input data_out, input evicted,
                    input evicted_key, input occupancy, output ready);
endinterface

// ===== hdl/lrukc_table.sv =====
module lrukc_table import lrukc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CAP_W-1:0] i_cap,
    input  t_req             i_req,
    output t_rsp             o_rsp,
    output t_stat            o_stat
);

    logic [KEY_W-1:0]      r_key  [ENTRIES];
    logic [DATA_WIDTH-1:0] r_data [ENTRIES];
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [RANK_W-1:0]     r_rank [ENTRIES];
    logic [RANK_W-1:0]     n_rank [ENTRIES];
    logic [CNT_W-1:0]      r_live, n_live;

    logic [CNT_W-1:0]      eff_cap;
    logic                  busy;
    logic [ENTRIES-1:0]    match, evict_oh, free_oh, wr_oh, v_after;
    logic                  hit, taken;
    logic [RANK_W-1:0]     hit_rank;
    logic [DATA_WIDTH-1:0] hit_data;
    logic [KEY_W-1:0]      ev_key;

    // capacity 0 counts as 1, anything above the table size as the table size
    always_comb begin
        if (i_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(i_cap) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(i_cap);
        end
    end

    assign busy = (r_live > eff_cap);

    // parallel search, and the least recent slot for eviction
    always_comb begin
        hit_rank = '0;
        hit_data = '0;
        ev_key   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]    = r_valid[i] && (r_key[i] == i_req.key);
            evict_oh[i] = r_valid[i] && (CNT_W'(r_rank[i]) == (r_live - CNT_W'(1)));
            hit_rank    = hit_rank | (match[i] ? r_rank[i] : '0);
            hit_data    = hit_data | (match[i] ? r_data[i] : '0);
            ev_key      = ev_key | (evict_oh[i] ? r_key[i] : '0);
        end
        hit = |match;
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_live  = r_live;
        wr_oh   = '0;
        v_after = r_valid;
        free_oh = '0;
        taken   = 1'b0;
        o_rsp   = '0;

        if (busy) begin
            // silent trim after a capacity shrink
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (CNT_W'(r_rank[i]) >= eff_cap)) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end
            end
            n_live = eff_cap;
        end else if (i_req.vld) begin
            unique case (i_req.op)
                OP_LOOKUP, OP_INSERT: begin
                    if (hit) begin
                        o_rsp.hit      = 1'b1;
                        o_rsp.data_out = DOUT_W'(hit_data);
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (match[i]) begin
                                n_rank[i] = '0;
                            end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                                n_rank[i] = r_rank[i] + RANK_W'(1);
                            end
                        end
                    end else if (i_req.op == OP_INSERT) begin
                        if (r_live >= eff_cap) begin
                            o_rsp.evicted     = 1'b1;
                            o_rsp.evicted_key = ev_key;
                            v_after           = r_valid & ~evict_oh;
                        end
                        // lowest free slot takes the new key
                        for (int i = 0; i < ENTRIES; i++) begin
                            free_oh[i] = !v_after[i] && !taken;
                            taken      = taken || !v_after[i];
                        end
                        wr_oh = free_oh;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (free_oh[i]) begin
                                n_rank[i] = '0;
                            end else if (v_after[i]) begin
                                n_rank[i] = r_rank[i] + RANK_W'(1);
                            end else begin
                                n_rank[i] = '0;
                            end
                        end
                        n_valid = v_after | free_oh;
                        n_live  = r_live - CNT_W'(o_rsp.evicted) + CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_valid = '0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        n_rank[i] = '0;
                    end
                    n_live = '0;
                end
                default: begin
                end
            endcase
        end
        o_rsp.occupancy = OCC_W'(n_live);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_live  <= n_live;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (wr_oh[i]) begin
                r_key[i]  <= i_req.key;
                r_data[i] <= DATA_WIDTH'(i_req.data_in);
            end
        end
    end

    assign o_stat.busy      = busy;
    assign o_stat.live      = r_live;
    assign o_stat.valid_map = r_valid;

endmodule

// ===== hdl/lru_keyed_cache_table.sv =====
// Fully associative LRU key/data table, 16 entries held in flip-flops.
// Input channel i_in carries one word per operation: op (lookup, insert if
// absent, clear), a 64-bit key and a data handle. Output channel o_out gives
// one result word per operation: hit, stored data, evicted flag and key,
// and occupancy after the operation.
// An accepted word is registered, processed when it advances (parallel key
// compare and rank update) and its result registered in the output register.
// Throughput: one word per cycle while results are taken and no trim runs,
// set by the search and rank update over the register-held table.
// The output register holds its result while o_out.ready is low; the input
// register still takes one more word, then i_in.ready drops until the
// result is taken.
// i_cfg_we / i_cfg_wdata write the capacity register (0 counts as 1).
// A shrink below the live count trims the least recent entries silently;
// while the trim is under way, i_in.ready is low.
// Synchronous active-low reset empties the table and sets capacity to 16;
// stored keys and data are not cleared, only their valid bits.
module lru_keyed_cache_table import lrukc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lrukc_in_if.sink         i_in,
    lrukc_out_if.source      o_out,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    logic [CAP_W-1:0] r_cap;
    logic             r_in_vld;
    logic [OP_W-1:0]  r_in_op;
    logic [KEY_W-1:0] r_in_key;
    logic [DIN_W-1:0] r_in_data;
    logic             r_out_vld;
    t_rsp             r_out;

    t_req  tbl_req;
    t_rsp  tbl_rsp;
    t_stat tbl_stat;
    logic  adv;
    logic  in_acc;

    // stage advances when it holds a word, the result slot is free or being emptied, and no trim is under way
    assign adv     = r_in_vld && (!r_out_vld || o_out.ready) && !tbl_stat.busy;
    assign i_in.ready = (!r_in_vld || adv) && !tbl_stat.busy;
    assign in_acc  = i_in.valid && i_in.ready;

    assign tbl_req.vld     = adv;
    assign tbl_req.op      = r_in_op;
    assign tbl_req.key     = r_in_key;
    assign tbl_req.data_in = r_in_data;

    lrukc_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp),
        .o_stat  (tbl_stat)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_op   <= i_in.op;
            r_in_key  <= i_in.key;
            r_in_data <= i_in.data_in;
        end
        if (adv) begin
            r_out <= tbl_rsp;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.hit         = r_out.hit;
    assign o_out.data_out    = r_out.data_out;
    assign o_out.evicted     = r_out.evicted;
    assign o_out.evicted_key = r_out.evicted_key;
    assign o_out.occupancy   = r_out.occupancy;

`ifndef SYNTH
    // live count agrees with the number of valid slots
    a_live_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(tbl_stat.valid_map) == int'(tbl_stat.live))
        else $error("live count disagrees with valid map");

    // a hit never evicts
    a_hit_no_evict : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.hit && o_out.evicted))
        else $error("hit and eviction in one result");

    // no word is taken in while a trim is under way
    a_trim_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_stat.busy |-> (!i_in.ready && !adv))
        else $error("word moved during trim");

    // a processed word always lands in the output register
    a_adv_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("result lost");
`endif

endmodule
